FILE: rtl/lcs_pkg.sv
package lcs_pkg;

  // Cube geometry
  localparam int LAYERS         = 5;
  localparam int LEDS_PER_LAYER = 25;
  localparam int TOTAL_LEDS     = LAYERS * LEDS_PER_LAYER;
  localparam int LAYER_W        = (LAYERS > 1) ? $clog2(LAYERS) : 1;
  localparam int POS_W          = (LEDS_PER_LAYER > 1) ? $clog2(LEDS_PER_LAYER) : 1;

  // Field widths fixed by the interface
  localparam int IDX_W    = 7;
  localparam int LEVEL_W  = 2;
  localparam int WORD_W   = 32;
  localparam int ENABLE_W = 5;
  localparam int COUNT_W  = 8;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_ANIM_WRAP   = 1'b0;
  localparam logic REG_BUTTON_WRAP = 1'b1;

  // Reset values
  localparam logic [COUNT_W-1:0] ANIM_WRAP_RST    = 8'd3;
  localparam logic [COUNT_W-1:0] BUTTON_WRAP_RST  = 8'd150;
  localparam logic [COUNT_W-1:0] ANIM_COUNT_RST   = 8'd0;
  localparam logic [COUNT_W-1:0] BUTTON_COUNT_RST = 8'd2;

  // LED levels
  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_HALF = 2'd2;

  typedef enum logic [1:0] {
    CMD_WRITE       = 2'd0,
    CMD_TICK        = 2'd1,
    CMD_TAKE_ANIM   = 2'd2,
    CMD_TAKE_BUTTON = 2'd3
  } cmd_t;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_FRAME = 2'd1;
  localparam logic [1:0] KIND_FLAG  = 2'd2;

  typedef struct packed {
    cmd_t               command;
    logic [IDX_W-1:0]   led_index;
    logic [LEVEL_W-1:0] led_level;
  } in_word_t;

  typedef struct packed {
    logic [1:0]          result_kind;
    logic [WORD_W-1:0]   shift_word;
    logic [ENABLE_W-1:0] layer_enable;
    logic                flag_value;
  } out_word_t;

  // Write request into the level store, index already split into row and column
  typedef struct packed {
    logic               en;
    logic [LAYER_W-1:0] layer;
    logic [POS_W-1:0]   pos;
    logic [LEVEL_W-1:0] level;
  } store_wr_t;

  // Split an LED number into layer and position; en is low past the last LED
  function automatic store_wr_t led_split(logic [IDX_W-1:0] idx, logic [LEVEL_W-1:0] level);
    store_wr_t r;
    r.en    = 1'b0;
    r.layer = '0;
    r.pos   = '0;
    r.level = level;
    for (int k = 0; k < LAYERS; k++) begin
      if (int'(idx) >= k * LEDS_PER_LAYER && int'(idx) < (k + 1) * LEDS_PER_LAYER) begin
        r.en    = 1'b1;
        r.layer = LAYER_W'(k);
        r.pos   = POS_W'(int'(idx) - k * LEDS_PER_LAYER);
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/lcs_regs.sv
module lcs_regs
  import lcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [CFG_AW-1:0]  paddr,
  input  logic [CFG_DW-1:0]  pwdata,
  output logic [CFG_DW-1:0]  prdata,
  output logic               pready,
  output logic [COUNT_W-1:0] anim_wrap,
  output logic [COUNT_W-1:0] button_wrap
);

  logic [COUNT_W-1:0] anim_wrap_r, anim_wrap_nxt;
  logic [COUNT_W-1:0] button_wrap_r, button_wrap_nxt;
  logic               wr_en;
  logic               reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[CFG_AW-1];

  always_comb begin
    anim_wrap_nxt   = anim_wrap_r;
    button_wrap_nxt = button_wrap_r;
    prdata          = '0;
    case (reg_sel)
      REG_ANIM_WRAP: begin
        prdata = CFG_DW'(anim_wrap_r);
        if (wr_en) anim_wrap_nxt = pwdata[COUNT_W-1:0];
      end
      REG_BUTTON_WRAP: begin
        prdata = CFG_DW'(button_wrap_r);
        if (wr_en) button_wrap_nxt = pwdata[COUNT_W-1:0];
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anim_wrap_r   <= ANIM_WRAP_RST;
      button_wrap_r <= BUTTON_WRAP_RST;
    end else begin
      anim_wrap_r   <= anim_wrap_nxt;
      button_wrap_r <= button_wrap_nxt;
    end
  end

  assign anim_wrap   = anim_wrap_r;
  assign button_wrap = button_wrap_r;

endmodule

FILE: rtl/lcs_divider.sv
module lcs_divider
  import lcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [COUNT_W-1:0] count_init,
  input  logic [COUNT_W-1:0] wrap,
  input  logic               tick,
  input  logic               take,
  output logic               flag
);

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               flag_r, flag_nxt;

  always_comb begin
    count_nxt = count_r;
    flag_nxt  = flag_r;
    if (tick) begin
      if (count_r == wrap) begin
        count_nxt = '0;
        flag_nxt  = 1'b1;
      end else begin
        count_nxt = count_r + COUNT_W'(1);
      end
    end
    if (take) flag_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= count_init;
      flag_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      flag_r  <= flag_nxt;
    end
  end

  assign flag = flag_r;

endmodule

FILE: rtl/lcs_store.sv
module lcs_store
  import lcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  store_wr_t          wr,
  input  logic [LAYER_W-1:0] rd_layer,
  input  logic               phase,
  output logic [WORD_W-1:0]  row_word
);

  logic [LEVEL_W-1:0] level_r [LAYERS][LEDS_PER_LAYER];
  logic [LEVEL_W-1:0] row     [LEDS_PER_LAYER];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < LAYERS; l++) begin
        for (int p = 0; p < LEDS_PER_LAYER; p++) begin
          level_r[l][p] <= '0;
        end
      end
    end else if (wr.en) begin
      level_r[wr.layer][wr.pos] <= wr.level;
    end
  end

  // LED at position i lands on bit LEDS_PER_LAYER-1-i, higher bits stay zero
  always_comb begin
    row      = level_r[rd_layer];
    row_word = '0;
    for (int i = 0; i < LEDS_PER_LAYER; i++) begin
      row_word[LEDS_PER_LAYER-1-i] = (row[i] == LEVEL_FULL) ||
                                     (row[i] == LEVEL_HALF && phase);
    end
  end

endmodule

FILE: rtl/led_cube_layer_scanner.sv
// Channel  | Dir | Handshake                  | Word
// ---------+-----+----------------------------+---------------------------------
// in_      | in  | in_valid / in_ready        | in_word_t: command, index, level
// out_     | out | out_valid / out_ready      | out_word_t: kind, word, enable, flag
// cfg      | in  | psel/penable/pwrite/pready | anim_wrap @0x0, button_wrap @0x4
//
// Each word passes through the input register and then the result register;
// a new word is accepted every cycle while the result register is empty or being drained.
// The logic ahead of the result register and the divider registers holds one row
// select of the level store and the divider compare.
// Reset (rst_n low, synchronous) clears all levels, flags, layer, phase and
// both pipeline valids, and loads the divider counts with their start values.
// A stall on out_ready holds the result and lets one
// more word enter the input register before in_ready drops.
module led_cube_layer_scanner
  import lcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // input words
  input  logic               in_valid,
  output logic               in_ready,
  input  in_word_t           in_data,
  // result words
  output logic               out_valid,
  input  logic               out_ready,
  output out_word_t          out_data,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [CFG_AW-1:0]  paddr,
  input  logic [CFG_DW-1:0]  pwdata,
  output logic [CFG_DW-1:0]  prdata,
  output logic               pready
);

  // Input register stage
  logic      s1_valid_r, s1_valid_nxt;
  in_word_t  s1_word_r;
  // Result register stage
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r, out_word_nxt;

  // Scan state
  logic [LAYER_W-1:0] layer_r, layer_nxt;
  logic               phase_r, phase_nxt;

  logic               advance;
  logic               fire;
  logic               do_tick;
  logic               take_anim;
  logic               take_button;
  logic               anim_flag;
  logic               button_flag;
  logic [COUNT_W-1:0] anim_wrap;
  logic [COUNT_W-1:0] button_wrap;
  logic [WORD_W-1:0]  row_word;
  logic [ENABLE_W-1:0] enable_vec;
  store_wr_t          store_wr;

  // Result register frees up when empty or being drained this cycle
  assign advance  = !out_valid_r || out_ready;
  assign fire     = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;

  assign do_tick     = fire && (s1_word_r.command == CMD_TICK);
  assign take_anim   = fire && (s1_word_r.command == CMD_TAKE_ANIM);
  assign take_button = fire && (s1_word_r.command == CMD_TAKE_BUTTON);

  // Drop out-of-range writes; the write is still acknowledged below
  always_comb begin
    store_wr    = led_split(s1_word_r.led_index, s1_word_r.led_level);
    store_wr.en = store_wr.en && fire && (s1_word_r.command == CMD_WRITE);
  end

  lcs_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .anim_wrap   (anim_wrap),
    .button_wrap (button_wrap)
  );

  lcs_divider u_anim_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .count_init (ANIM_COUNT_RST),
    .wrap       (anim_wrap),
    .tick       (do_tick),
    .take       (take_anim),
    .flag       (anim_flag)
  );

  lcs_divider u_button_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .count_init (BUTTON_COUNT_RST),
    .wrap       (button_wrap),
    .tick       (do_tick),
    .take       (take_button),
    .flag       (button_flag)
  );

  lcs_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (store_wr),
    .rd_layer (layer_r),
    .phase    (phase_r),
    .row_word (row_word)
  );

  // One-hot layer enable; layers past the enable width show none
  always_comb begin
    enable_vec = '0;
    for (int n = 0; n < ENABLE_W; n++) begin
      enable_vec[n] = (int'(layer_r) == n);
    end
  end

  // Build the result word and step the scan state on a tick
  always_comb begin
    out_word_nxt = '0;
    layer_nxt    = layer_r;
    phase_nxt    = phase_r;
    case (s1_word_r.command)
      CMD_WRITE: begin
        out_word_nxt.result_kind = KIND_ACK;
      end
      CMD_TICK: begin
        out_word_nxt.result_kind  = KIND_FRAME;
        out_word_nxt.shift_word   = row_word;
        out_word_nxt.layer_enable = enable_vec;
        if (fire) begin
          phase_nxt = !phase_r;
          layer_nxt = (int'(layer_r) >= LAYERS - 1) ? '0 : layer_r + LAYER_W'(1);
        end
      end
      CMD_TAKE_ANIM: begin
        out_word_nxt.result_kind = KIND_FLAG;
        out_word_nxt.flag_value  = anim_flag;
      end
      CMD_TAKE_BUTTON: begin
        out_word_nxt.result_kind = KIND_FLAG;
        out_word_nxt.flag_value  = button_flag;
      end
      default: out_word_nxt = '0;
    endcase
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (fire) s1_valid_nxt = 1'b0;
    if (in_valid && in_ready) s1_valid_nxt = 1'b1;
    out_valid_nxt = advance ? fire : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      layer_r     <= '0;
      phase_r     <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      layer_r     <= layer_nxt;
      phase_r     <= phase_nxt;
    end
  end

  // Payload registers: capture on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_word_r <= in_data;
    if (fire) out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule

FILE: rtl/lcs_checker.sv
module lcs_checker
  import lcs_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input out_word_t         out_data
);

  a_kind_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.result_kind == KIND_ACK ||
                   out_data.result_kind == KIND_FRAME ||
                   out_data.result_kind == KIND_FLAG))
    else $error("result kind out of range");

  a_frame_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.result_kind == KIND_FRAME) |->
      ($onehot(out_data.layer_enable) && out_data.flag_value == 1'b0 &&
       (out_data.shift_word >> LEDS_PER_LAYER) == '0))
    else $error("frame word malformed");

  a_non_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.result_kind != KIND_FRAME) |->
      (out_data.shift_word == '0 && out_data.layer_enable == '0))
    else $error("unused frame fields not zero");

  a_ack_no_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.result_kind == KIND_ACK) |-> out_data.flag_value == 1'b0)
    else $error("write acknowledge carries a flag");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result word changed");

endmodule

bind led_cube_layer_scanner lcs_checker u_lcs_checker (.*);

FILE: tb/tb_led_cube_layer_scanner.sv
`timescale 1ns / 100ps

import lcs_pkg::*;

// Mirror of the scanner: level store, layer walk, brightness phase, both
// dividers and their sticky flags, plus the queue of results still owed.
class cube_scan_model;
  logic [LEVEL_W-1:0] levels [TOTAL_LEDS];
  int unsigned        layer_cnt;
  bit                 phase;
  logic [COUNT_W-1:0] anim_cnt, button_cnt;
  logic [COUNT_W-1:0] anim_wrap, button_wrap;
  bit                 anim_flag, button_flag;
  out_word_t          owed_words [$];
  int unsigned        failures, words_checked;
  int unsigned        n_writes, n_stray_writes, n_ticks, n_flag_reads, n_flags_set;

  function new();
    foreach (levels[k]) levels[k] = '0;
    layer_cnt   = 0;
    phase       = 1'b0;
    anim_cnt    = ANIM_COUNT_RST;
    button_cnt  = BUTTON_COUNT_RST;
    anim_wrap   = ANIM_WRAP_RST;
    button_wrap = BUTTON_WRAP_RST;
    anim_flag   = 1'b0;
    button_flag = 1'b0;
    failures = 0;
    words_checked = 0;
    n_writes = 0;
    n_stray_writes = 0;
    n_ticks = 0;
    n_flag_reads = 0;
    n_flags_set = 0;
  endfunction

  function void log_fail(string msg);
    failures++;
    if (failures <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  function logic [COUNT_W-1:0] div_next(logic [COUNT_W-1:0] cnt, logic [COUNT_W-1:0] wrap);
    return (cnt == wrap) ? '0 : cnt + 1'b1;
  endfunction

  // Apply one accepted command word and queue the result it owes.
  function void accept_cmd(in_word_t w);
    out_word_t          r;
    int unsigned        base;
    logic [LEVEL_W-1:0] lvl;
    r = '0;
    case (w.command)
      CMD_WRITE: begin
        r.result_kind = KIND_ACK;
        n_writes++;
        if (int'(w.led_index) < TOTAL_LEDS) levels[w.led_index] = w.led_level;
        else n_stray_writes++;
      end
      CMD_TICK: begin
        r.result_kind = KIND_FRAME;
        n_ticks++;
        if (anim_cnt == anim_wrap) anim_flag = 1'b1;
        anim_cnt = div_next(anim_cnt, anim_wrap);
        if (button_cnt == button_wrap) button_flag = 1'b1;
        button_cnt = div_next(button_cnt, button_wrap);
        base = layer_cnt * LEDS_PER_LAYER;
        for (int i = 0; i < LEDS_PER_LAYER; i++) begin
          lvl = (base + i < TOTAL_LEDS) ? levels[base + i] : '0;
          r.shift_word[LEDS_PER_LAYER-1-i] = (lvl == LEVEL_FULL) ||
                                             (lvl == LEVEL_HALF && phase);
        end
        if (layer_cnt < ENABLE_W) r.layer_enable[layer_cnt] = 1'b1;
        phase     = ~phase;
        layer_cnt = (layer_cnt + 1 >= LAYERS) ? 0 : layer_cnt + 1;
      end
      CMD_TAKE_ANIM: begin
        r.result_kind = KIND_FLAG;
        r.flag_value  = anim_flag;
        n_flag_reads++;
        n_flags_set += anim_flag;
        anim_flag = 1'b0;
      end
      default: begin
        r.result_kind = KIND_FLAG;
        r.flag_value  = button_flag;
        n_flag_reads++;
        n_flags_set += button_flag;
        button_flag = 1'b0;
      end
    endcase
    owed_words.push_back(r);
  endfunction

  function void compare_result(out_word_t got);
    out_word_t want;
    if (owed_words.size() == 0) begin
      log_fail($sformatf("result word with nothing owed: %h", got));
      return;
    end
    want = owed_words.pop_front();
    words_checked++;
    if (got.result_kind !== want.result_kind || got.shift_word !== want.shift_word ||
        got.layer_enable !== want.layer_enable || got.flag_value !== want.flag_value)
      log_fail($sformatf({"result %0d (exp/act): kind %0d/%0d word %08h/%08h ",
                          "enable %05b/%05b flag %0b/%0b"}, words_checked,
                         want.result_kind, got.result_kind, want.shift_word, got.shift_word,
                         want.layer_enable, got.layer_enable, want.flag_value,
                         got.flag_value));
  endfunction
endclass

module tb_led_cube_layer_scanner;

  localparam int WATCHDOG_LIMIT = 4000;  // quiet cycles before giving up
  localparam int HOLD_CYCLES    = 80;    // long receiver hold-off
  localparam int TAIL_CYCLES    = 8;     // settle time after the last result
  localparam int PHASE_ITEMS    = 386;   // random words per divider setting

  // Register map: register i sits at byte address 4*i
  localparam logic [CFG_AW-1:0] ADDR_ANIM_WRAP   = CFG_AW'(4 * int'(REG_ANIM_WRAP));
  localparam logic [CFG_AW-1:0] ADDR_BUTTON_WRAP = CFG_AW'(4 * int'(REG_BUTTON_WRAP));

  // Levels that light nothing
  localparam logic [LEVEL_W-1:0] LEVEL_OFF  = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_DARK = 2'd3;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_word_t          in_data;
  logic              out_valid;
  logic              out_ready;
  out_word_t         out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  cube_scan_model model;
  int unsigned    send_idle_pct;
  int unsigned    recv_idle_pct;
  bit             hold_req;
  int unsigned    quiet_cycles;

  led_cube_layer_scanner i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: drop out_ready at random, or hold it low for a long stretch
  // when asked so the pipeline fills and backs up into in_ready.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Sample both channels at the rising edge: feed accepted words to the
  // model, check accepted results, and watch for a stuck run.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if (in_valid && in_ready) model.accept_cmd(in_data);
      if (out_valid && out_ready) model.compare_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("ERROR: no handshake for %0d cycles, %0d results still owed",
                 WATCHDOG_LIMIT, model.owed_words.size());
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic in_word_t mk_cmd(cmd_t c, int unsigned idx, logic [LEVEL_W-1:0] lvl);
    in_word_t w;
    w.command   = c;
    w.led_index = IDX_W'(idx);
    w.led_level = lvl;
    return w;
  endfunction

  // Random word: mostly writes and ticks, some flag reads. Unused fields
  // stay random so every input bit toggles; a few writes land past the
  // last LED.
  function automatic in_word_t random_cmd();
    in_word_t    w;
    int unsigned pick;
    pick        = $urandom_range(99);
    w.led_index = IDX_W'($urandom_range(127));
    w.led_level = LEVEL_W'($urandom);
    if (pick < 45) begin
      w.command = CMD_WRITE;
      if ($urandom_range(19) == 0) w.led_index = IDX_W'($urandom_range(127, TOTAL_LEDS));
      else w.led_index = IDX_W'($urandom_range(TOTAL_LEDS - 1));
    end else if (pick < 80) begin
      w.command = CMD_TICK;
    end else if (pick < 90) begin
      w.command = CMD_TAKE_ANIM;
    end else begin
      w.command = CMD_TAKE_BUTTON;
    end
    return w;
  endfunction

  // Offer one word at a falling edge and hold it until accepted; then
  // at random idle the sender. Returns at a falling edge.
  task automatic send_cmd(input in_word_t w);
    in_data  = w;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(2, 1)) @(negedge clk);
    end
  endtask

  // Stop sending and wait for every owed result, then let the pipe settle.
  task automatic drain();
    in_valid = 1'b0;
    while (model.owed_words.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  // Write one wrap register (setup + access), mirror it, then read it back.
  task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [COUNT_W-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = CFG_DW'(value);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_ANIM_WRAP) model.anim_wrap = value;
    else model.button_wrap = value;
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[COUNT_W-1:0] !== value)
      model.log_fail($sformatf("register at %0h reads %0d, written %0d",
                               addr, prdata[COUNT_W-1:0], value));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Retune both dividers with the block idle.
  task automatic retune(input logic [COUNT_W-1:0] anim, input logic [COUNT_W-1:0] button);
    drain();
    cfg_write(ADDR_ANIM_WRAP, anim);
    cfg_write(ADDR_BUTTON_WRAP, button);
  endtask

  // Random words; at hold_at start a long receiver hold-off while sending
  // on, at pause_at stop sending until every result is back.
  task automatic run_phase(input int count, input int hold_at, input int pause_at);
    for (int n = 0; n < count; n++) begin
      if (n == hold_at) hold_req = 1'b1;
      if (n == pause_at) begin
        in_valid = 1'b0;
        while (model.owed_words.size() != 0) @(negedge clk);
      end
      send_cmd(random_cmd());
    end
  endtask

  initial begin
    model         = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    send_idle_pct = 25;
    recv_idle_pct = 25;
    hold_req      = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed: corner and centre LEDs at every level, writes past the last LED,
    // flag reads before any wrap, then two full scans so each layer shows
    // in both brightness phases, and flag reads after the animation divider wraps.
    send_cmd(mk_cmd(CMD_WRITE, 0, LEVEL_FULL));
    send_cmd(mk_cmd(CMD_WRITE, 24, LEVEL_HALF));
    send_cmd(mk_cmd(CMD_WRITE, 12, LEVEL_DARK));
    send_cmd(mk_cmd(CMD_WRITE, TOTAL_LEDS - 1, LEVEL_FULL));
    send_cmd(mk_cmd(CMD_WRITE, 100, LEVEL_HALF));
    send_cmd(mk_cmd(CMD_WRITE, TOTAL_LEDS, LEVEL_FULL));
    send_cmd(mk_cmd(CMD_WRITE, 127, LEVEL_HALF));
    send_cmd(mk_cmd(CMD_TAKE_ANIM, 0, LEVEL_OFF));
    send_cmd(mk_cmd(CMD_TAKE_BUTTON, 127, LEVEL_DARK));
    for (int t = 0; t < 2 * LAYERS; t++) send_cmd(mk_cmd(CMD_TICK, 0, LEVEL_OFF));
    send_cmd(mk_cmd(CMD_TAKE_ANIM, 0, LEVEL_OFF));
    send_cmd(mk_cmd(CMD_TAKE_ANIM, 0, LEVEL_OFF));
    send_cmd(mk_cmd(CMD_TAKE_BUTTON, 0, LEVEL_OFF));
    send_cmd(mk_cmd(CMD_WRITE, 24, LEVEL_OFF));

    // Reset wrap values
    run_phase(PHASE_ITEMS, -1, -1);

    // Widest dividers; back up the pipe with a long receiver hold-off
    retune(8'd255, 8'd255);
    run_phase(PHASE_ITEMS, 100, -1);

    // Wraps well below the running counts: both dividers run past 255
    // and come around before flagging. Pause the sender mid-phase.
    retune(8'd1, 8'd0);
    run_phase(PHASE_ITEMS, -1, 150);

    // Narrowest animation divider, no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    retune(8'd0, 8'd255);
    run_phase(PHASE_ITEMS, -1, -1);

    // Random wraps, idling back on, both kinds of pressure again
    send_idle_pct = 25;
    recv_idle_pct = 25;
    retune(COUNT_W'($urandom_range(255)), COUNT_W'($urandom_range(255)));
    run_phase(PHASE_ITEMS, 200, 300);

    drain();

    $display("Ran %0d LED writes (%0d past the last LED), %0d scan ticks, %0d flag reads (%0d set)",
             model.n_writes, model.n_stray_writes, model.n_ticks, model.n_flag_reads,
             model.n_flags_set);
    $display("Checked %0d results over five divider settings with backpressure; %0d failures",
             model.words_checked, model.failures);
    if (model.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
